// ----- rtl/pdc_pkg.sv -----
// Shared types and constants for the packet deframer with rotate-add checksum.
`default_nettype none

package pdc_pkg;

   // Default payload limit per frame, in bytes
   localparam int MAX_PAYLOAD_DEF = 128;

   // Frame trailer bytes
   localparam logic [7:0] BYTE_CR = 8'h0D;
   localparam logic [7:0] BYTE_LF = 8'h0A;

   // Left shift that completes a right rotate by one bit of a byte
   localparam int ROT_LEFT = 7;

   // Result kinds
   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_END     = 1'b1;

   // One result item plus its valid flag
   typedef struct packed {
      logic       valid;
      logic       kind;
      logic [7:0] payload_byte;
      logic [7:0] frame_id;
      logic [7:0] frame_length;
      logic       frame_good;
   } pdc_result_type;

   // Parser position, for checks at the top level
   typedef struct packed {
      logic at_payload;
      logic at_end;
   } pdc_status_type;

endpackage : pdc_pkg

`default_nettype wire

// ----- rtl/pdc_if.sv -----
// Channel interfaces: received byte stream and result items.
`default_nettype none

interface pdc_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface : pdc_req_if

interface pdc_rsp_if;
   logic       valid;
   logic       ready;
   logic       kind;
   logic [7:0] payload_byte;
   logic [7:0] frame_id;
   logic [7:0] frame_length;
   logic       frame_good;

   modport source (output valid, output kind, output payload_byte, output frame_id,
                   output frame_length, output frame_good, input ready);
   modport sink   (input valid, input kind, input payload_byte, input frame_id,
                   input frame_length, input frame_good, output ready);
endinterface : pdc_rsp_if

`default_nettype wire

// ----- rtl/packet_deframer_checksum.sv -----
// Serial packet deframer with rotate-add checksum.
//
// req_ch carries received bytes, one per item. Frames run: head, length, ID,
// payload (length minus one bytes), tail, checksum, CR, LF. rsp_ch gives one
// item per payload byte (kind 0) and one end report per frame (kind 1) with
// ID, length and a good flag covering checksum, CR, LF and the payload limit.
// Payload bytes past MaxPayload are checked but not reported.
//
// A byte accepted into the input register is parsed when the parser steps, and
// its result is loaded into the result register, which drives rsp_ch. Throughput
// is one byte per cycle while the receiver does not stall, set by the single
// parser step between the input register and the result register.
//
// Reset (synchronous, active high) returns the parser to waiting for a head
// byte and empties both registers. When the receiver stalls, the result
// register holds its item; one more byte waits in the input register, then
// req_ch.ready drops. Bytes that give no result pass through during a stall.
`default_nettype none

module packet_deframer_checksum import pdc_pkg::*; #(
   parameter int MaxPayload = MAX_PAYLOAD_DEF
) (
   input wire logic  clock,
   input wire logic  reset,
   pdc_req_if.sink   req_ch,
   pdc_rsp_if.source rsp_ch
);

   logic           held_valid;
   logic [7:0]     held_byte;
   logic           out_free;
   logic           step;
   pdc_result_type result;
   pdc_status_type status;

   // A byte steps the parser unless its result would find the output full
   assign step = held_valid && (out_free || !result.valid);

   pdc_in_stage u_in_stage (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_ch.valid),
      .req_ready  (req_ch.ready),
      .req_byte   (req_ch.rx_byte),
      .take       (step),
      .held_valid (held_valid),
      .held_byte  (held_byte)
   );

   pdc_parser #(
      .MaxPayload (MaxPayload)
   ) u_parser (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .rx_byte (held_byte),
      .result  (result),
      .status  (status)
   );

   pdc_out_stage u_out_stage (
      .clock  (clock),
      .reset  (reset),
      .load   (step && result.valid),
      .result (result),
      .free   (out_free),
      .rsp_ch (rsp_ch)
   );

   // A parsed LF byte always leaves an end report in the result register
   a_end_report : assert property (@(posedge clock) disable iff (reset)
      step && status.at_end |=> rsp_ch.valid && rsp_ch.kind == KIND_END)
      else $error("LF byte did not produce an end report");

   // A waiting input byte is not lost or altered
   a_in_hold : assert property (@(posedge clock) disable iff (reset)
      held_valid && !step |=> held_valid && $stable(held_byte))
      else $error("input byte dropped while waiting");

   // Payload items never claim a good frame
   a_pay_good : assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid && rsp_ch.kind == KIND_PAYLOAD |-> !rsp_ch.frame_good)
      else $error("payload item with good flag set");

   // Outside the payload phase only the LF byte yields a result
   a_no_stray : assert property (@(posedge clock) disable iff (reset)
      held_valid && !status.at_payload && !status.at_end |-> !result.valid)
      else $error("result from a header or trailer byte");

endmodule : packet_deframer_checksum

`default_nettype wire

// ----- rtl/pdc_in_stage.sv -----
// Input register: holds one received byte until the parser takes it.
`default_nettype none

module pdc_in_stage (
   input  wire logic       clock,
   input  wire logic       reset,
   input  wire logic       req_valid,
   output      logic       req_ready,
   input  wire logic [7:0] req_byte,
   input  wire logic       take,
   output      logic       held_valid,
   output      logic [7:0] held_byte
);

   logic       valid_ff, valid_in;
   logic [7:0] byte_ff, byte_in;
   logic       load;

   // Room when empty or when the held item leaves this cycle
   assign req_ready = !valid_ff || take;
   assign load      = req_valid && req_ready;

   always_comb begin
      valid_in = valid_ff;
      byte_in  = byte_ff;
      if (load) begin
         valid_in = 1'b1;
         byte_in  = req_byte;
      end else if (take) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      byte_ff <= byte_in;
   end

   assign held_valid = valid_ff;
   assign held_byte  = byte_ff;

endmodule : pdc_in_stage

`default_nettype wire

// ----- rtl/pdc_parser.sv -----
// Frame parser: position state machine, running checksum and result forming.
`default_nettype none

module pdc_parser import pdc_pkg::*; #(
   parameter int MaxPayload = MAX_PAYLOAD_DEF
) (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           step,
   input  wire logic [7:0]     rx_byte,
   output      pdc_result_type result,
   output      pdc_status_type status
);

   localparam logic [7:0] MaxPay8 = 8'(MaxPayload);

   typedef enum logic [7:0] {
      PH_HEAD = 8'b0000_0001,
      PH_LEN  = 8'b0000_0010,
      PH_ID   = 8'b0000_0100,
      PH_PAY  = 8'b0000_1000,
      PH_TAIL = 8'b0001_0000,
      PH_SUM  = 8'b0010_0000,
      PH_CR   = 8'b0100_0000,
      PH_LF   = 8'b1000_0000
   } phase_type;

   phase_type  phase_ff, phase_in;
   logic [7:0] length_ff, length_in;
   logic [7:0] id_ff, id_in;
   logic [7:0] count_ff, count_in;
   logic [7:0] sum_ff, sum_in;
   logic [7:0] rx_sum_ff, rx_sum_in;
   logic       bad_ff, bad_in;

   logic [7:0] expected;
   logic [7:0] rotated;
   logic [7:0] count_inc;

   // Payload bytes the length field promises (zero length acts as one)
   assign expected  = (length_ff == 8'd0) ? 8'd0 : length_ff - 8'd1;
   assign rotated   = (sum_ff >> 1) | (sum_ff << ROT_LEFT);
   assign count_inc = count_ff + 8'd1;

   // Next state and result for the byte at hand
   always_comb begin
      phase_in  = phase_ff;
      length_in = length_ff;
      id_in     = id_ff;
      count_in  = count_ff;
      sum_in    = sum_ff;
      rx_sum_in = rx_sum_ff;
      bad_in    = bad_ff;
      result    = '0;
      result.frame_id     = id_ff;
      result.frame_length = length_ff;

      unique case (phase_ff)
         PH_HEAD: begin
            phase_in = PH_LEN;
         end
         PH_LEN: begin
            length_in = rx_byte;
            phase_in  = PH_ID;
         end
         PH_ID: begin
            id_in    = rx_byte;
            sum_in   = rx_byte;
            count_in = 8'd0;
            bad_in   = 1'b0;
            phase_in = (expected == 8'd0) ? PH_TAIL : PH_PAY;
         end
         PH_PAY: begin
            // bytes past the limit still enter the checksum
            if (count_ff < MaxPay8) begin
               result.valid        = 1'b1;
               result.kind         = KIND_PAYLOAD;
               result.payload_byte = rx_byte;
            end
            sum_in   = rotated + rx_byte;
            count_in = count_inc;
            if (count_inc >= expected) begin
               phase_in = PH_TAIL;
            end
         end
         PH_TAIL: begin
            phase_in = PH_SUM;
         end
         PH_SUM: begin
            rx_sum_in = rx_byte;
            phase_in  = PH_CR;
         end
         PH_CR: begin
            if (rx_byte != BYTE_CR) begin
               bad_in = 1'b1;
            end
            phase_in = PH_LF;
         end
         PH_LF: begin
            result.valid      = 1'b1;
            result.kind       = KIND_END;
            result.frame_good = !bad_ff && (rx_byte == BYTE_LF) &&
                                (rx_sum_ff == sum_ff) && (expected <= MaxPay8);
            phase_in = PH_HEAD;
         end
         default: begin
            phase_in = PH_HEAD;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_HEAD;
         length_ff <= 8'd0;
         id_ff     <= 8'd0;
         count_ff  <= 8'd0;
         sum_ff    <= 8'd0;
         rx_sum_ff <= 8'd0;
         bad_ff    <= 1'b0;
      end else if (step) begin
         phase_ff  <= phase_in;
         length_ff <= length_in;
         id_ff     <= id_in;
         count_ff  <= count_in;
         sum_ff    <= sum_in;
         rx_sum_ff <= rx_sum_in;
         bad_ff    <= bad_in;
      end
   end

   assign status.at_payload = (phase_ff == PH_PAY);
   assign status.at_end     = (phase_ff == PH_LF);

endmodule : pdc_parser

`default_nettype wire

// ----- rtl/pdc_out_stage.sv -----
// Result register: holds one result item until the receiver takes it.
`default_nettype none

module pdc_out_stage import pdc_pkg::*; (
   input  wire logic           clock,
   input  wire logic           reset,
   input  wire logic           load,
   input  wire pdc_result_type result,
   output      logic           free,
   pdc_rsp_if.source           rsp_ch
);

   logic           valid_ff, valid_in;
   pdc_result_type data_ff, data_in;

   // Free when empty or when the held item is taken this cycle
   assign free = !valid_ff || rsp_ch.ready;

   always_comb begin
      valid_in = valid_ff;
      data_in  = data_ff;
      if (load) begin
         valid_in = 1'b1;
         data_in  = result;
      end else if (rsp_ch.ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
      data_ff <= data_in;
   end

   assign rsp_ch.valid        = valid_ff;
   assign rsp_ch.kind         = data_ff.kind;
   assign rsp_ch.payload_byte = data_ff.payload_byte;
   assign rsp_ch.frame_id     = data_ff.frame_id;
   assign rsp_ch.frame_length = data_ff.frame_length;
   assign rsp_ch.frame_good   = data_ff.frame_good;

endmodule : pdc_out_stage

`default_nettype wire

// ----- bench/tb_packet_deframer_checksum.sv -----
// Self-checking bench for the packet deframer: byte stream in, payload and end reports out.
`timescale 1ns / 1ps

module tb_packet_deframer_checksum import pdc_pkg::*;;

   localparam int PayloadLimit = MAX_PAYLOAD_DEF;

   // Parser position, tracked alongside the block
   typedef enum logic [2:0] {
      AT_HEAD, AT_LENGTH, AT_ID, AT_PAYLOAD, AT_TAIL, AT_CHECKSUM, AT_CR, AT_LF
   } frame_pos_type;

   // Ways a generated frame can be damaged
   typedef enum int {
      FLAW_NONE, FLAW_SUM, FLAW_CR, FLAW_LF, FLAW_TRAILER
   } frame_flaw_type;

   typedef struct packed {
      logic       kind;
      logic [7:0] payload_byte;
      logic [7:0] frame_id;
      logic [7:0] frame_length;
      logic       frame_good;
   } deframed_type;

   typedef struct {
      logic [7:0] data;
      bit         drain_first;
   } stream_byte_type;

   logic clock;
   logic reset;

   pdc_req_if req_bus ();
   pdc_rsp_if rsp_bus ();

   packet_deframer_checksum dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_bus),
      .rsp_ch (rsp_bus)
   );

   stream_byte_type byte_backlog[$];
   deframed_type    pending_outputs[$];

   int   mismatch_count  = 0;
   int   predicted_count = 0;
   int   delivered_count = 0;
   logic long_hold       = 1'b0;

   // Parser copy
   frame_pos_type pos;
   logic [7:0]    frame_len;
   logic [7:0]    frame_id;
   logic [7:0]    bytes_taken;
   logic [7:0]    csum;
   logic [7:0]    got_csum;
   logic          cr_bad;

   int tx_gap    = 0;
   int rx_stall  = 0;
   bit tx_steady = 1'b0;
   bit rx_steady = 1'b0;

   initial clock = 1'b0;
   always #10 clock = ~clock;

   // Rotate right by one, then add the byte
   function automatic logic [7:0] rot_add(input logic [7:0] sum, input logic [7:0] b);
      return {sum[0], sum[7:1]} + b;
   endfunction

   // Random byte guaranteed to differ from v
   function automatic logic [7:0] other_than(input logic [7:0] v);
      return v ^ 8'($urandom_range(1, 255));
   endfunction

   // Idle length: mostly short, now and then long
   function automatic int idle_span();
      int r;
      r = $urandom_range(0, 99);
      if (r < 70) return $urandom_range(1, 2);
      else if (r < 95) return $urandom_range(3, 8);
      else return $urandom_range(20, 60);
   endfunction

   task automatic flag_mismatch(input string what, input int got, input int want);
      mismatch_count++;
      $display("%0t ns mismatch on %s: got 0x%0h, expected 0x%0h", $time, what, got, want);
   endtask

   // Queue one frame of len bytes (ID plus payload); fill < 0 means random content
   task automatic queue_frame(input int len, input logic [7:0] id, input int fill,
                              input frame_flaw_type flaw, input bit drain);
      logic [7:0] sum;
      logic [7:0] b;
      logic [7:0] edge_byte;
      int         body;
      body      = (len == 0) ? 0 : len - 1;
      edge_byte = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      byte_backlog.push_back('{edge_byte, drain});
      byte_backlog.push_back('{8'(len), 1'b0});
      byte_backlog.push_back('{id, 1'b0});
      sum = id;
      for (int i = 0; i < body; i++) begin
         b   = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
         sum = rot_add(sum, b);
         byte_backlog.push_back('{b, 1'b0});
      end
      edge_byte = (fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill);
      byte_backlog.push_back('{edge_byte, 1'b0});
      // checksum, CR, LF, damaged as asked
      case (flaw)
         FLAW_SUM: begin
            byte_backlog.push_back('{sum ^ (8'h01 << $urandom_range(0, 7)), 1'b0});
            byte_backlog.push_back('{BYTE_CR, 1'b0});
            byte_backlog.push_back('{BYTE_LF, 1'b0});
         end
         FLAW_CR: begin
            byte_backlog.push_back('{sum, 1'b0});
            byte_backlog.push_back('{other_than(BYTE_CR), 1'b0});
            byte_backlog.push_back('{BYTE_LF, 1'b0});
         end
         FLAW_LF: begin
            byte_backlog.push_back('{sum, 1'b0});
            byte_backlog.push_back('{BYTE_CR, 1'b0});
            byte_backlog.push_back('{other_than(BYTE_LF), 1'b0});
         end
         FLAW_TRAILER: begin
            byte_backlog.push_back('{8'($urandom_range(0, 255)), 1'b0});
            byte_backlog.push_back('{8'($urandom_range(0, 255)), 1'b0});
            byte_backlog.push_back('{8'($urandom_range(0, 255)), 1'b0});
         end
         default: begin
            byte_backlog.push_back('{sum, 1'b0});
            byte_backlog.push_back('{BYTE_CR, 1'b0});
            byte_backlog.push_back('{BYTE_LF, 1'b0});
         end
      endcase
   endtask

   // Advance the parser copy by one accepted byte, queue what it should emit
   task automatic track_frame_byte(input logic [7:0] b);
      deframed_type out;
      int           body;
      case (pos)
         AT_HEAD: pos = AT_LENGTH;
         AT_LENGTH: begin
            frame_len = b;
            pos       = AT_ID;
         end
         AT_ID: begin
            frame_id    = b;
            csum        = b;
            bytes_taken = 8'h00;
            cr_bad      = 1'b0;
            pos         = (frame_len <= 8'd1) ? AT_TAIL : AT_PAYLOAD;
         end
         AT_PAYLOAD: begin
            body = (frame_len == 8'd0) ? 0 : int'(frame_len) - 1;
            // bytes past the limit still feed the checksum
            if (bytes_taken < PayloadLimit) begin
               out = '{KIND_PAYLOAD, b, frame_id, frame_len, 1'b0};
               pending_outputs.push_back(out);
               predicted_count++;
            end
            csum        = rot_add(csum, b);
            bytes_taken = bytes_taken + 8'd1;
            if (bytes_taken >= body) pos = AT_TAIL;
         end
         AT_TAIL: pos = AT_CHECKSUM;
         AT_CHECKSUM: begin
            got_csum = b;
            pos      = AT_CR;
         end
         AT_CR: begin
            if (b != BYTE_CR) cr_bad = 1'b1;
            pos = AT_LF;
         end
         default: begin
            body = (frame_len == 8'd0) ? 0 : int'(frame_len) - 1;
            out  = '{KIND_END, 8'h00, frame_id, frame_len,
                     !cr_bad && b == BYTE_LF && got_csum == csum && body <= PayloadLimit};
            pending_outputs.push_back(out);
            predicted_count++;
            pos = AT_HEAD;
         end
      endcase
   endtask

   task automatic check_output();
      deframed_type want;
      if (pending_outputs.size() == 0) begin
         flag_mismatch("result with none awaited, kind", rsp_bus.kind, 0);
      end else begin
         want = pending_outputs.pop_front();
         if (rsp_bus.kind !== want.kind)
            flag_mismatch("kind", rsp_bus.kind, want.kind);
         if (rsp_bus.payload_byte !== want.payload_byte)
            flag_mismatch("payload_byte", rsp_bus.payload_byte, want.payload_byte);
         if (rsp_bus.frame_id !== want.frame_id)
            flag_mismatch("frame_id", rsp_bus.frame_id, want.frame_id);
         if (rsp_bus.frame_length !== want.frame_length)
            flag_mismatch("frame_length", rsp_bus.frame_length, want.frame_length);
         if (rsp_bus.frame_good !== want.frame_good)
            flag_mismatch("frame_good", rsp_bus.frame_good, want.frame_good);
      end
   endtask

   // Byte driver: one item offered at a time, gaps between items
   always @(posedge clock) begin : drive_bytes
      logic slot_free;
      if (reset) begin
         req_bus.valid   <= 1'b0;
         req_bus.rx_byte <= 8'h00;
         tx_gap          = 0;
         pos             = AT_HEAD;
         frame_len       = 8'h00;
         frame_id        = 8'h00;
         bytes_taken     = 8'h00;
         csum            = 8'h00;
         got_csum        = 8'h00;
         cr_bad          = 1'b0;
      end else begin
         slot_free = !req_bus.valid || req_bus.ready;
         if (req_bus.valid && req_bus.ready) track_frame_byte(req_bus.rx_byte);
         if ($urandom_range(0, 399) == 0) tx_steady = !tx_steady;
         if (slot_free) begin
            if (tx_gap > 0) begin
               tx_gap--;
               req_bus.valid <= 1'b0;
            end else if (byte_backlog.size() != 0 &&
                         !(byte_backlog[0].drain_first && predicted_count != delivered_count)) begin
               req_bus.valid   <= 1'b1;
               req_bus.rx_byte <= byte_backlog[0].data;
               void'(byte_backlog.pop_front());
               if (!tx_steady && $urandom_range(0, 99) < 30) tx_gap = idle_span();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // Result monitor: checks each accepted item, stalls at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready   <= 1'b0;
         rx_stall        = 0;
         delivered_count <= 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            check_output();
            delivered_count <= delivered_count + 1;
         end
         if ($urandom_range(0, 399) == 0) rx_steady = !rx_steady;
         if (rx_stall > 0) rx_stall--;
         else if (!rx_steady && $urandom_range(0, 99) < 25) rx_stall = idle_span();
         rsp_bus.ready <= !long_hold && rx_stall == 0;
      end
   end

   // One long receiver hold-off while bytes keep coming, so the block backs up
   initial begin : receiver_hold
      wait (delivered_count >= 300);
      @(posedge clock);
      long_hold <= 1'b1;
      repeat (400) @(posedge clock);
      long_hold <= 1'b0;
   end

   initial begin : watchdog
      #30000000;
      $display("packet_deframer_checksum verification failed");
      $finish;
   end

   initial begin : run
      int r;
      int len;
      frame_flaw_type flaw;
      reset = 1'b1;

      // Directed frames: length extremes, payload limit edges, each kind of damage
      queue_frame(0, 8'h00, -1, FLAW_NONE, 1'b0);
      queue_frame(1, 8'hFF, -1, FLAW_NONE, 1'b0);
      queue_frame(2, 8'h5A, 8'h00, FLAW_NONE, 1'b0);
      queue_frame(3, 8'hA5, 8'hFF, FLAW_NONE, 1'b1);
      queue_frame(PayloadLimit + 1, 8'h3C, -1, FLAW_NONE, 1'b0);
      queue_frame(PayloadLimit + 2, 8'hC3, -1, FLAW_NONE, 1'b0);
      queue_frame(255, 8'h81, -1, FLAW_NONE, 1'b1);
      queue_frame(4, 8'h11, -1, FLAW_SUM, 1'b0);
      queue_frame(4, 8'h22, -1, FLAW_CR, 1'b0);
      queue_frame(4, 8'h44, -1, FLAW_LF, 1'b0);
      queue_frame(0, 8'h88, -1, FLAW_TRAILER, 1'b0);

      // Random frames, mostly short and well formed
      while (byte_backlog.size() < 1950) begin
         r = $urandom_range(0, 99);
         if (r < 75) len = $urandom_range(0, 10);
         else if (r < 93) len = $urandom_range(11, 40);
         else if (r < 98) len = $urandom_range(PayloadLimit - 28, PayloadLimit + 7);
         else len = $urandom_range(200, 255);
         r = $urandom_range(0, 99);
         if (r < 70) flaw = FLAW_NONE;
         else if (r < 78) flaw = FLAW_SUM;
         else if (r < 85) flaw = FLAW_CR;
         else if (r < 92) flaw = FLAW_LF;
         else flaw = FLAW_TRAILER;
         queue_frame(len, 8'($urandom_range(0, 255)), -1, flaw, $urandom_range(0, 29) == 0);
      end
      // trailing raw noise, may leave a frame open
      repeat (30) byte_backlog.push_back('{8'($urandom_range(0, 255)), 1'b0});

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      while (byte_backlog.size() != 0 || req_bus.valid || predicted_count != delivered_count)
         @(posedge clock);
      repeat (20) @(posedge clock);
      if (predicted_count != delivered_count)
         flag_mismatch("results never delivered", delivered_count, predicted_count);

      if (mismatch_count == 0)
         $display("packet_deframer_checksum verification clean");
      else
         $display("packet_deframer_checksum verification failed");
      $finish;
   end

endmodule

// ----- sim.f -----
rtl/pdc_pkg.sv
rtl/pdc_if.sv
rtl/pdc_in_stage.sv
rtl/pdc_parser.sv
rtl/pdc_out_stage.sv
rtl/packet_deframer_checksum.sv
bench/tb_packet_deframer_checksum.sv
